FILE: hdl/life_generation_engine_top_defines.svh
// ----------------------------------------------------------------------------
// Life generation engine assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_ENGINE_TOP_DEFINES_SVH
`define LIFE_GENERATION_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define LGE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LGE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/lge_pkg.sv
// ----------------------------------------------------------------------------
// Life generation engine package
// Shared types, codes and defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lge_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int OP_W    = 2;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int GEN_W   = 16;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 7'd64;
  localparam logic [CFG_W-1:0] COL_COUNT_RST = 7'd64;

  // B3/S23 neighbour counts
  localparam logic [3:0] CNT_SURVIVE = 4'd2;
  localparam logic [3:0] CNT_BIRTH   = 4'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_GEN,
    ST_DONE
  } lge_state_t;

  // one column of the three-row window
  typedef struct packed {
    logic up;
    logic mid;
    logic down;
  } col_bits_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctl_t;

endpackage

FILE: hdl/lge_req_if.sv
// ----------------------------------------------------------------------------
// Life generation engine request channel
// Valid/ready channel carrying one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lge_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [5:0]  row;
  logic [5:0]  col;
  logic        alive_in;
  logic [15:0] generations;

  modport source (output valid, op, row, col, alive_in, generations, input ready);
  modport sink   (input valid, op, row, col, alive_in, generations, output ready);
endinterface

FILE: hdl/lge_rsp_if.sv
// ----------------------------------------------------------------------------
// Life generation engine response channel
// Valid/ready channel carrying one response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lge_rsp_if;
  logic       valid;
  logic       ready;
  logic       cell_value;
  logic [1:0] done_op;

  modport source (output valid, cell_value, done_op, input ready);
  modport sink   (input valid, cell_value, done_op, output ready);
endinterface

FILE: hdl/life_generation_engine_top.sv
// ----------------------------------------------------------------------------
// Life generation engine top level
// B3/S23 life grid in a row memory, swept by a chain of column cells.
// ----------------------------------------------------------------------------
// After reset the grid memory is cleared one row a cycle, during which no
// request is taken. A cell write or read goes from acceptance through a
// memory read, an update and the response register, which waits while an
// earlier response is uncollected. In a run each generation streams every
// row once through the single memory read port, and the cell chain rewrites
// each row in place in the same cycle as its lower neighbour arrives. Runs
// of zero generations or on zero rows go straight to the response.
// One request is in flight at a time; a new one is taken while a response
// still waits to be collected.
`timescale 1ns / 1ps
`include "life_generation_engine_top_defines.svh"

module life_generation_engine_top #(
  parameter int MAX_ROWS = lge_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lge_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lge_pkg::CFG_W-1:0]      cfg_wdata,
  lge_req_if.sink                        in_req,
  lge_rsp_if.source                      out_rsp
);
  import lge_pkg::*;

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int EW = (RW > CFG_W) ? RW : CFG_W;
  localparam int KW = EW + 1;

  // configuration
  logic [CFG_W-1:0] row_count_r;
  logic [CFG_W-1:0] col_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_RST;
      col_count_r <= COL_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ROW_COUNT: row_count_r <= cfg_wdata;
        CFG_COL_COUNT: col_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [EW-1:0]       r_eff;
  logic [MAX_COLS-1:0] col_mask;

  always_comb begin
    if (EW'(row_count_r) < EW'(MAX_ROWS)) begin
      r_eff = EW'(row_count_r);
    end else begin
      r_eff = EW'(MAX_ROWS);
    end
  end

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
    assign col_mask[c] = (CFG_W'(c) < col_count_r);
  end

  // request latch
  logic [OP_W-1:0]  op_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic             alive_r;
  logic [GEN_W-1:0] gens_left_r;
  logic [GEN_W-1:0] gens_left_nxt;
  logic             res_val_r;
  logic             res_val_nxt;

  // control
  lge_state_t state_r;
  lge_state_t state_nxt;
  logic [KW-1:0] k_r;
  logic [KW-1:0] k_nxt;
  logic          in_acc;
  logic          out_load;

  logic               out_valid_r;
  logic               out_val_r;
  logic [OP_W-1:0]    out_op_r;

  // memory
  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_q_r;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [MAX_COLS-1:0] mem_wd;

  // cell chain
  cell_ctl_t           cell_ctl;
  logic                row_vld;
  col_bits_t           col_w [MAX_COLS];
  logic [MAX_COLS-1:0] new_row;

  logic                in_area;
  logic [MAX_COLS-1:0] bit_sel;
  logic [KW-1:0]       k_last;

  assign in_acc  = in_req.valid && in_req.ready;
  assign k_last  = KW'(r_eff) + KW'(1);
  assign bit_sel = MAX_COLS'(1) << col_r;
  assign in_area = (EW'(row_r) < r_eff) && (CFG_W'(col_r) < col_count_r) &&
                   (CFG_W'(col_r) < CFG_W'(MAX_COLS));

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
    col_bits_t left_b;
    col_bits_t right_b;

    if (c == 0) begin : g_l0
      assign left_b = '0;
    end else begin : g_l
      assign left_b = col_w[c-1];
    end
    if (c == MAX_COLS - 1) begin : g_r0
      assign right_b = '0;
    end else begin : g_r
      assign right_b = col_w[c+1];
    end

    lge_cell u_cell (
      .clk       (clk),
      .ctl_i     (cell_ctl),
      .in_use_i  (col_mask[c]),
      .row_vld_i (row_vld),
      .rd_bit_i  (rd_q_r[c]),
      .left_i    (left_b),
      .right_i   (right_b),
      .col_o     (col_w[c]),
      .new_bit_o (new_row[c])
    );
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    gens_left_nxt = gens_left_r;
    res_val_nxt   = res_val_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (k_r == KW'(MAX_ROWS - 1)) begin
          state_nxt = ST_IDLE;
          k_nxt     = '0;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_val_nxt   = 1'b0;
          k_nxt         = '0;
          gens_left_nxt = in_req.generations;
          priority if (in_req.op == OP_WRITE || in_req.op == OP_READ) begin
            state_nxt = ST_ACCESS;
          end else if (in_req.op == OP_RUN && in_req.generations != '0 &&
                       r_eff != '0) begin
            state_nxt = ST_GEN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_ACCESS: begin
        res_val_nxt = (op_r == OP_READ) && in_area && (|(rd_q_r & bit_sel));
        state_nxt   = ST_DONE;
      end
      ST_GEN: begin
        if (k_r == k_last) begin
          k_nxt = '0;
          if (gens_left_r == GEN_W'(1)) begin
            state_nxt = ST_DONE;
          end else begin
            gens_left_nxt = gens_left_r - GEN_W'(1);
          end
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_req.ready   = 1'b0;
    out_load       = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = AW'(k_r);
    mem_wd         = '0;
    rd_addr        = AW'(row_r);
    cell_ctl.clr   = 1'b0;
    cell_ctl.shift = 1'b0;
    row_vld        = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        in_req.ready = 1'b1;
        rd_addr      = AW'(in_req.row);
      end
      ST_ACCESS: begin
        mem_we = (op_r == OP_WRITE) && in_area;
        mem_wa = AW'(row_r);
        mem_wd = alive_r ? (rd_q_r | bit_sel) : (rd_q_r & ~bit_sel);
      end
      ST_GEN: begin
        rd_addr        = AW'(k_r);
        cell_ctl.clr   = (k_r == '0);
        cell_ctl.shift = (k_r != '0);
        row_vld        = (k_r <= KW'(r_eff));
        mem_we         = (k_r >= KW'(2));
        mem_wa         = AW'(k_r - KW'(2));
        mem_wd         = new_row;
      end
      ST_DONE: begin
        out_load = !out_valid_r || out_rsp.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    gens_left_r <= gens_left_nxt;
    res_val_r   <= res_val_nxt;
    if (in_acc) begin
      op_r    <= in_req.op;
      row_r   <= in_req.row;
      col_r   <= in_req.col;
      alive_r <= in_req.alive_in;
    end
    if (out_load) begin
      out_val_r <= res_val_r;
      out_op_r  <= op_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q_r <= mem[rd_addr];
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.cell_value = out_val_r;
  assign out_rsp.done_op    = out_op_r;

  `LGE_ASSERT_NOW(a_no_wr_idle, state_r == ST_IDLE, !mem_we, "grid written while idle")
  `LGE_ASSERT_NOW(a_gen_bound, state_r == ST_GEN, k_r <= k_last, "row sweep overran area")
  `LGE_ASSERT_NOW(a_rsp_src, $rose(out_valid_r), $past(state_r) == ST_DONE, "response without completion")
  `LGE_ASSERT_NXT(a_zero_run, in_acc && in_req.op == OP_RUN && in_req.generations == '0, state_r == ST_DONE, "empty run did not complete at once")

endmodule

FILE: hdl/lge_cell.sv
// ----------------------------------------------------------------------------
// Life generation engine column cell
// Holds one column of the row window and computes that column's next state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lge_cell (
  input  logic              clk,
  input  lge_pkg::cell_ctl_t ctl_i,
  input  logic              in_use_i,
  input  logic              row_vld_i,
  input  logic              rd_bit_i,
  input  lge_pkg::col_bits_t left_i,
  input  lge_pkg::col_bits_t right_i,
  output lge_pkg::col_bits_t col_o,
  output logic              new_bit_o
);
  import lge_pkg::*;

  logic       up_r;
  logic       mid_r;
  logic       raw_r;
  logic       down;
  logic [3:0] cnt;

  assign down  = rd_bit_i & row_vld_i & in_use_i;
  assign col_o = '{up: up_r, mid: mid_r, down: down};

  assign cnt = 4'($countones({left_i.up, left_i.mid, left_i.down,
                              right_i.up, right_i.mid, right_i.down,
                              up_r, down}));

  // columns outside the area keep their stored bit
  assign new_bit_o = in_use_i ? ((cnt == CNT_BIRTH) | ((cnt == CNT_SURVIVE) & mid_r))
                              : raw_r;

  always_ff @(posedge clk) begin
    if (ctl_i.clr) begin
      up_r  <= 1'b0;
      mid_r <= 1'b0;
    end else if (ctl_i.shift) begin
      up_r  <= mid_r;
      mid_r <= down;
      raw_r <= rd_bit_i;
    end
  end

endmodule

FILE: test/life_grid_monitor.sv
// ----------------------------------------------------------------------------
// Life grid monitor
// Watches the configuration port and both channels of the life engine, keeps
// its own copy of the grid and area registers, works out the response to each
// accepted request and compares it with what the engine returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module life_grid_monitor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lge_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lge_pkg::CFG_W-1:0]     cfg_wdata,
  lge_req_if                            req_mon,
  lge_rsp_if                            rsp_mon,
  output int                            fail_count,
  output int                            replies_owed
);
  import lge_pkg::*;

  typedef logic [DEF_MAX_COLS-1:0] grid_row_t;

  typedef struct packed {
    logic            cell_value;
    logic [OP_W-1:0] done_op;
  } cell_reply_t;

  grid_row_t        grid [DEF_MAX_ROWS];
  logic [CFG_W-1:0] row_count_q;
  logic [CFG_W-1:0] col_count_q;
  cell_reply_t      replies_due [$];
  cell_reply_t      oldest;

  function automatic int unsigned live_rows();
    return (row_count_q < DEF_MAX_ROWS) ? row_count_q : DEF_MAX_ROWS;
  endfunction

  function automatic int unsigned live_cols();
    return (col_count_q < DEF_MAX_COLS) ? col_count_q : DEF_MAX_COLS;
  endfunction

  function automatic grid_row_t live_mask();
    grid_row_t ones;
    ones = '1;
    return ones >> (DEF_MAX_COLS - live_cols());
  endfunction

  // bit-sliced neighbour count: ones, twos and a sticky four-or-more flag
  function automatic grid_row_t evolve_row(grid_row_t above, grid_row_t mid,
                                           grid_row_t below, grid_row_t mask);
    grid_row_t plane [8];
    grid_row_t ones;
    grid_row_t twos;
    grid_row_t many;
    grid_row_t carry;
    plane[0] = (above << 1) & mask;
    plane[1] = above;
    plane[2] = above >> 1;
    plane[3] = (mid << 1) & mask;
    plane[4] = mid >> 1;
    plane[5] = (below << 1) & mask;
    plane[6] = below;
    plane[7] = below >> 1;
    ones = '0;
    twos = '0;
    many = '0;
    for (int i = 0; i < 8; i++) begin
      carry = ones & plane[i];
      ones  = ones ^ plane[i];
      many  = many | (twos & carry);
      twos  = twos ^ carry;
    end
    return ((twos & ~ones & ~many & mid) | (twos & ones & ~many)) & mask;
  endfunction

  // one generation in place; returns whether any cell changed
  function automatic bit step_generation();
    int unsigned nrows;
    grid_row_t   mask;
    grid_row_t   prev_old;
    grid_row_t   cur;
    grid_row_t   below;
    grid_row_t   nxt;
    bit          changed;
    nrows    = live_rows();
    mask     = live_mask();
    prev_old = '0;
    changed  = 1'b0;
    for (int unsigned r = 0; r < nrows; r++) begin
      cur   = grid[r] & mask;
      below = (r + 1 < nrows) ? (grid[r + 1] & mask) : '0;
      nxt   = (grid[r] & ~mask) | evolve_row(prev_old, cur, below, mask);
      if (nxt != grid[r]) changed = 1'b1;
      grid[r]  = nxt;
      prev_old = cur;
    end
    return changed;
  endfunction

  function automatic cell_reply_t predict_reply(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
                                                logic [COL_W-1:0] col, logic alive,
                                                logic [GEN_W-1:0] gens);
    cell_reply_t reply;
    bit          in_area;
    reply.cell_value = 1'b0;
    reply.done_op    = op;
    in_area = (row < live_rows()) && (col < live_cols());
    case (op)
      OP_WRITE: begin
        if (in_area) grid[row][col] = alive;
      end
      OP_RUN: begin
        // a still grid stays still, so the rest of the run is skipped
        for (int g = 0; g < gens; g++) begin
          if (!step_generation()) break;
        end
      end
      OP_READ: begin
        if (in_area) reply.cell_value = grid[row][col];
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      row_count_q = ROW_COUNT_RST;
      col_count_q = COL_COUNT_RST;
      for (int r = 0; r < DEF_MAX_ROWS; r++) grid[r] = '0;
      replies_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_ROW_COUNT: row_count_q = cfg_wdata;
          CFG_COL_COUNT: col_count_q = cfg_wdata;
          default: begin
          end
        endcase
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (replies_due.size() == 0) begin
          $error("response with no request outstanding: done_op %0d", rsp_mon.done_op);
          fail_count++;
        end else begin
          oldest = replies_due.pop_front();
          if (rsp_mon.cell_value !== oldest.cell_value) begin
            $error("cell_value: expected %0d, actual %0d", oldest.cell_value,
                   rsp_mon.cell_value);
            fail_count++;
          end
          if (rsp_mon.done_op !== oldest.done_op) begin
            $error("done_op: expected %0d, actual %0d", oldest.done_op, rsp_mon.done_op);
            fail_count++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        replies_due.push_back(predict_reply(req_mon.op, req_mon.row, req_mon.col,
                                            req_mon.alive_in, req_mon.generations));
      end
    end
    replies_owed = replies_due.size();
  end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Life generation engine testbench
// Drives cell writes, reads and generation runs into the engine over a range
// of grid areas, with random idling on both channels; the grid monitor checks
// every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import lge_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 92;

  bit                   clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   fail_total;
  int                   replies_owed;
  bit                   idling_on;
  int                   long_runs_left;
  int unsigned          focus_row;
  int unsigned          focus_col;
  logic [CFG_W-1:0]     rows_cfg;
  logic [CFG_W-1:0]     cols_cfg;

  lge_req_if req_ch ();
  lge_rsp_if rsp_ch ();

  life_generation_engine_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch)
  );

  life_grid_monitor grid_monitor (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .fail_count   (fail_total),
    .replies_owed (replies_owed)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("life_generation_engine_top verification failed");
    $finish;
  end

  // response side back-pressure
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic post_request(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
                              input logic [COL_W-1:0] col, input logic alive,
                              input logic [GEN_W-1:0] gens);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op;
    req_ch.row         <= row;
    req_ch.col         <= col;
    req_ch.alive_in    <= alive;
    req_ch.generations <= gens;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (replies_owed != 0) @(negedge clk);
  endtask

  task automatic set_area(input logic [CFG_W-1:0] nrows, input logic [CFG_W-1:0] ncols);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_ROW_COUNT;
    cfg_wdata <= nrows;
    @(negedge clk);
    cfg_idx   <= CFG_COL_COUNT;
    cfg_wdata <= ncols;
    @(negedge clk);
    cfg_we   <= 1'b0;
    rows_cfg  = nrows;
    cols_cfg  = ncols;
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_ROW_COUNT;
    cfg_wdata          = '0;
    req_ch.valid       = 1'b0;
    req_ch.op          = OP_WRITE;
    req_ch.row         = '0;
    req_ch.col         = '0;
    req_ch.alive_in    = 1'b0;
    req_ch.generations = '0;
    idling_on          = 1'b1;
    long_runs_left     = 3;
    focus_row          = 10;
    focus_col          = 20;
    rows_cfg           = ROW_COUNT_RST;
    cols_cfg           = COL_COUNT_RST;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // freshly cleared store, corners, spare op code, blinker
    post_request(OP_READ, 6'd63, 6'd63, 1'b0, 16'd0);
    post_request(OP_SPARE, 6'd21, 6'd42, 1'b1, 16'hA5A5);
    post_request(OP_WRITE, 6'd0, 6'd0, 1'b1, 16'd0);
    post_request(OP_WRITE, 6'd63, 6'd63, 1'b1, 16'd0);
    post_request(OP_WRITE, 6'd0, 6'd63, 1'b1, 16'd0);
    post_request(OP_WRITE, 6'd63, 6'd0, 1'b1, 16'd0);
    post_request(OP_READ, 6'd0, 6'd63, 1'b0, 16'd0);
    post_request(OP_WRITE, 6'd11, 6'd19, 1'b1, 16'd0);
    post_request(OP_WRITE, 6'd11, 6'd20, 1'b1, 16'd0);
    post_request(OP_WRITE, 6'd11, 6'd21, 1'b1, 16'd0);
    post_request(OP_RUN, 6'd0, 6'd0, 1'b0, 16'd0);
    post_request(OP_READ, 6'd11, 6'd21, 1'b0, 16'd0);
    post_request(OP_RUN, 6'd0, 6'd0, 1'b0, 16'd1);
    post_request(OP_READ, 6'd10, 6'd20, 1'b0, 16'd0);
    post_request(OP_READ, 6'd11, 6'd21, 1'b0, 16'd0);
    post_request(OP_WRITE, 6'd10, 6'd20, 1'b0, 16'd0);
    post_request(OP_RUN, 6'd0, 6'd0, 1'b0, 16'd2);
    post_request(OP_READ, 6'd0, 6'd0, 1'b0, 16'd0);
    settle();

    // single row: longest run, accesses beyond the area
    set_area(7'd1, 7'd64);
    post_request(OP_WRITE, 6'd0, 6'd3, 1'b1, 16'd0);
    post_request(OP_WRITE, 6'd0, 6'd4, 1'b1, 16'd0);
    post_request(OP_WRITE, 6'd0, 6'd5, 1'b1, 16'd0);
    post_request(OP_WRITE, 6'd1, 6'd0, 1'b1, 16'd0);
    post_request(OP_READ, 6'd1, 6'd0, 1'b0, 16'd0);
    post_request(OP_RUN, 6'd0, 6'd0, 1'b0, 16'hFFFF);
    post_request(OP_READ, 6'd0, 6'd4, 1'b0, 16'd0);
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin : random_phase
      logic [CFG_W-1:0] nrows_sel;
      logic [CFG_W-1:0] ncols_sel;
      case (phase)
        0:  begin nrows_sel = 7'd64;  ncols_sel = 7'd64;  end
        1:  begin nrows_sel = 7'd1;   ncols_sel = 7'd1;   end
        2:  begin nrows_sel = 7'd0;   ncols_sel = 7'd0;   end
        3:  begin nrows_sel = 7'd127; ncols_sel = 7'd127; end
        4:  begin nrows_sel = 7'd3;   ncols_sel = 7'd64;  end
        5:  begin nrows_sel = 7'd64;  ncols_sel = 7'd3;   end
        6:  begin nrows_sel = 7'd2;   ncols_sel = 7'd17;  end
        7:  begin nrows_sel = 7'd1;   ncols_sel = 7'd64;  end
        8:  begin nrows_sel = 7'd64;  ncols_sel = 7'd0;   end
        9:  begin nrows_sel = 7'd100; ncols_sel = 7'd65;  end
        12: begin nrows_sel = 7'd64;  ncols_sel = 7'd64;  end
        default: begin
          nrows_sel = CFG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(65, 127)
                                                         : $urandom_range(1, 64));
          ncols_sel = CFG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(65, 127)
                                                         : $urandom_range(1, 64));
        end
      endcase
      idling_on = (phase % 4 != 3) && (phase < PHASES - 2);
      set_area(nrows_sel, ncols_sel);
      for (int n = 0; n < PHASE_ITEMS; n++) begin : random_item
        int unsigned      nr;
        int unsigned      nc;
        int unsigned      pick;
        logic [OP_W-1:0]  op_sel;
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        logic             alive;
        logic [GEN_W-1:0] g;
        nr    = (rows_cfg < DEF_MAX_ROWS) ? rows_cfg : DEF_MAX_ROWS;
        nc    = (cols_cfg < DEF_MAX_COLS) ? cols_cfg : DEF_MAX_COLS;
        pick  = $urandom_range(0, 99);
        alive = ($urandom_range(0, 2) != 0);
        g     = GEN_W'($urandom());
        if ($urandom_range(0, 15) == 0) begin
          focus_row = $urandom_range(0, 63);
          focus_col = $urandom_range(0, 63);
        end
        // mostly inside the area, clustered so that patterns form
        if (nr == 0 || nc == 0 || $urandom_range(0, 19) == 0) begin
          r = ROW_W'($urandom_range(0, 63));
          c = COL_W'($urandom_range(0, 63));
        end else if ($urandom_range(0, 1) == 0) begin
          r = ROW_W'((focus_row + $urandom_range(0, 4)) % nr);
          c = COL_W'((focus_col + $urandom_range(0, 4)) % nc);
        end else begin
          r = ROW_W'($urandom_range(0, nr - 1));
          c = COL_W'($urandom_range(0, nc - 1));
        end
        if (pick < 42) begin
          op_sel = OP_WRITE;
        end else if (pick < 72) begin
          op_sel = OP_READ;
        end else if (pick < 96) begin
          op_sel = OP_RUN;
          if (nr == 0) begin
            g = GEN_W'($urandom_range(0, 65535));
          end else if (nr <= 2 && long_runs_left > 0 && $urandom_range(0, 5) == 0) begin
            g = GEN_W'($urandom_range(0, 65535));
            long_runs_left--;
          end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) g = GEN_W'($urandom_range(0, 3));
            else if (pick < 90) g = GEN_W'($urandom_range(4, 12));
            else g = GEN_W'($urandom_range(13, 40));
          end
        end else begin
          op_sel = OP_SPARE;
        end
        post_request(op_sel, r, c, alive, g);
      end
      settle();
    end

    repeat (20) @(negedge clk);
    if (fail_total == 0) begin
      $display("life_generation_engine_top verification clean");
    end else begin
      $display("life_generation_engine_top verification failed");
    end
    $finish;
  end

endmodule
